// ===== sv/mpui_pkg.sv =====
package mpui_pkg;

  // Player modes. These are also the codes on the status port.
  typedef enum logic [2:0] {
    MODE_SETUP  = 3'd0,
    MODE_CHOOSE = 3'd1,
    MODE_PLAY   = 3'd2,
    MODE_PAUSE  = 3'd3,
    MODE_PEND   = 3'd4,
    MODE_LOW    = 3'd5
  } mode_t;

  // Event codes
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_CW      = 3'd1;
  localparam logic [2:0] CMD_CCW     = 3'd2;
  localparam logic [2:0] CMD_SELECT  = 3'd3;
  localparam logic [2:0] CMD_PRESS   = 3'd4;
  localparam logic [2:0] CMD_RELEASE = 3'd5;

  // Transport button selector
  localparam logic [1:0] SEL_PREV = 2'd0;
  localparam logic [1:0] SEL_PLAY = 2'd1;
  localparam logic [1:0] SEL_NEXT = 2'd2;

  // Audio action codes
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_PAUSE  = 3'd2;
  localparam logic [2:0] ACT_RESUME = 3'd3;
  localparam logic [2:0] ACT_NEXT   = 3'd4;
  localparam logic [2:0] ACT_PREV   = 3'd5;

  // Register indexes
  localparam logic [1:0] REG_TRACK_COUNT = 2'd0;
  localparam logic [1:0] REG_PAGE_SIZE   = 2'd1;
  localparam logic [1:0] REG_LONG_PRESS  = 2'd2;

  localparam logic [7:0]  TRACK_COUNT_RST = 8'd1;
  localparam logic [4:0]  PAGE_SIZE_RST   = 5'd5;
  localparam logic [15:0] LONG_PRESS_RST  = 16'd500;

  // Ticks per second, minus one (wrap point of the sub-second counter)
  localparam logic [6:0] TICK_MOD_LAST = 7'd99;

  typedef struct packed {
    logic [7:0]  track_count;
    logic [4:0]  page_size;
    logic [15:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    mode_t       prior_mode;
    logic [1:0]  selector;
    logic [7:0]  track;
    logic [7:0]  top_entry;
    logic [15:0] seconds;
    logic [31:0] ticks;
    logic [6:0]  tick_mod;     // ticks mod 100, kept alongside the full count
    logic [15:0] press_start;
  } ui_state_t;

endpackage

// ===== sv/mpui_cfg_regs.sv =====
module mpui_cfg_regs
  import mpui_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.track_count      <= TRACK_COUNT_RST;
      cfg_r.page_size        <= PAGE_SIZE_RST;
      cfg_r.long_press_ticks <= LONG_PRESS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TRACK_COUNT: cfg_r.track_count      <= pwdata[7:0];
        REG_PAGE_SIZE:   cfg_r.page_size        <= pwdata[4:0];
        REG_LONG_PRESS:  cfg_r.long_press_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TRACK_COUNT: prdata = {24'd0, cfg_r.track_count};
      REG_PAGE_SIZE:   prdata = {27'd0, cfg_r.page_size};
      REG_LONG_PRESS:  prdata = {16'd0, cfg_r.long_press_ticks};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/mpui_step.sv =====
module mpui_step
  import mpui_pkg::*;
(
  input  cfg_t        cfg,
  input  ui_state_t   st,
  input  logic [2:0]  cmd,
  input  logic [15:0] dur,
  output ui_state_t   st_nxt,
  output logic [2:0]  act
);

  mode_t       mode_mid;     // mode after a press has been applied
  mode_t       mode_nxt;
  logic        is_tick;
  logic        is_press;
  logic [31:0] ticks_nxt;
  logic [6:0]  mod_nxt;
  logic [7:0]  trk_inc;
  logic [7:0]  trk_dec;
  logic [8:0]  page_end;
  logic        cw_scroll;
  logic        cw_wrap;
  logic [7:0]  top_scroll;
  logic [7:0]  count_m1;
  logic [7:0]  page_w;
  logic [7:0]  ccw_top;
  logic [7:0]  trk_fwd;
  logic [7:0]  trk_back;
  logic [15:0] held;
  logic [1:0]  sel_turn;

  assign is_tick  = (cmd == CMD_TICK);
  assign is_press = (cmd == CMD_PRESS);
  assign mode_mid = is_press ? MODE_PEND : st.mode;

  // 32-bit tick count; the mod-100 shadow restarts when the count wraps
  assign ticks_nxt = is_tick ? st.ticks + 32'd1 : st.ticks;
  always_comb begin
    if (!is_tick)
      mod_nxt = st.tick_mod;
    else if (st.ticks == 32'hFFFF_FFFF || st.tick_mod == TICK_MOD_LAST)
      mod_nxt = 7'd0;
    else
      mod_nxt = st.tick_mod + 7'd1;
  end

  // list arithmetic, modulo 256 except the 9-bit page_end and the 16-bit held
  assign page_w     = {3'd0, cfg.page_size};
  assign trk_inc    = st.track + 8'd1;
  assign trk_dec    = st.track - 8'd1;
  assign page_end   = {1'b0, st.top_entry} + {4'd0, cfg.page_size};
  assign cw_scroll  = ({1'b0, trk_inc} >= page_end);
  assign cw_wrap    = (trk_inc >= cfg.track_count);
  assign top_scroll = trk_inc - page_w + 8'd1;
  assign count_m1   = cfg.track_count - 8'd1;
  assign ccw_top    = (cfg.track_count > page_w) ? cfg.track_count - page_w : 8'd0;
  assign trk_fwd    = cw_wrap ? 8'd0 : trk_inc;
  assign trk_back   = (st.track == 8'd0) ? count_m1 : trk_dec;
  assign held       = ticks_nxt[15:0] - st.press_start;

  always_comb begin
    if (cmd == CMD_CW) begin
      case (st.selector)
        SEL_PREV: sel_turn = SEL_PLAY;
        SEL_PLAY: sel_turn = SEL_NEXT;
        default:  sel_turn = SEL_PREV;
      endcase
    end else begin
      case (st.selector)
        SEL_PREV: sel_turn = SEL_NEXT;
        SEL_PLAY: sel_turn = SEL_PREV;
        default:  sel_turn = SEL_PLAY;
      endcase
    end
  end

  // next mode
  always_comb begin
    mode_nxt = mode_mid;
    case (mode_mid)
      MODE_SETUP: begin
        if (cmd == CMD_SELECT) mode_nxt = MODE_CHOOSE;
      end
      MODE_CHOOSE: begin
        if (cmd == CMD_SELECT) mode_nxt = MODE_PLAY;
      end
      MODE_PLAY, MODE_PAUSE: begin
        if (cmd == CMD_SELECT) begin
          if (st.selector == SEL_PLAY && mode_mid == MODE_PLAY)
            mode_nxt = MODE_PAUSE;
          else
            mode_nxt = MODE_PLAY;
        end
      end
      MODE_PEND: begin
        if (cmd == CMD_RELEASE) begin
          if (held >= cfg.long_press_ticks)
            mode_nxt = MODE_LOW;
          else if (st.prior_mode == MODE_PLAY || st.prior_mode == MODE_PAUSE)
            mode_nxt = MODE_CHOOSE;
          else
            mode_nxt = st.prior_mode;
        end
      end
      default: ;
    endcase
  end

  // everything else the event changes
  always_comb begin
    st_nxt.mode        = mode_nxt;
    st_nxt.prior_mode  = is_press ? st.mode : st.prior_mode;
    st_nxt.press_start = is_press ? ticks_nxt[15:0] : st.press_start;
    st_nxt.ticks       = ticks_nxt;
    st_nxt.tick_mod    = mod_nxt;
    st_nxt.selector    = st.selector;
    st_nxt.track       = st.track;
    st_nxt.top_entry   = st.top_entry;
    st_nxt.seconds     = st.seconds;
    act                = ACT_NONE;
    case (mode_mid)
      MODE_CHOOSE: begin
        if (cmd == CMD_CW) begin
          if (cw_wrap) begin
            st_nxt.track     = 8'd0;
            st_nxt.top_entry = 8'd0;
          end else begin
            st_nxt.track = trk_inc;
            if (cw_scroll) st_nxt.top_entry = top_scroll;
          end
        end else if (cmd == CMD_CCW) begin
          if (st.track == 8'd0) begin
            st_nxt.track     = count_m1;
            st_nxt.top_entry = ccw_top;
          end else begin
            st_nxt.track = trk_dec;
            if (trk_dec < st.top_entry) st_nxt.top_entry = trk_dec;
          end
        end else if (cmd == CMD_SELECT) begin
          st_nxt.selector = SEL_PLAY;
          st_nxt.seconds  = 16'd0;
          act             = ACT_START;
        end
      end
      MODE_PLAY, MODE_PAUSE: begin
        if (is_tick) begin
          if (mode_mid == MODE_PLAY && mod_nxt == 7'd0 && st.seconds < dur)
            st_nxt.seconds = st.seconds + 16'd1;
        end else if (cmd == CMD_CW || cmd == CMD_CCW) begin
          st_nxt.selector = sel_turn;
        end else if (cmd == CMD_SELECT) begin
          if (st.selector == SEL_PLAY) begin
            act = (mode_mid == MODE_PLAY) ? ACT_PAUSE : ACT_RESUME;
          end else if (st.selector == SEL_NEXT) begin
            st_nxt.seconds = 16'd0;
            st_nxt.track   = trk_fwd;
            act            = ACT_NEXT;
          end else begin
            st_nxt.seconds = 16'd0;
            st_nxt.track   = trk_back;
            act            = ACT_PREV;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/media_player_ui_control_unit.sv =====
// Media player UI control unit.
//
// Input channel (in_valid / in_stall): one beat per UI event, in_cmd selects
// tick, rotate cw, rotate ccw, select, power press or power release;
// in_track_duration bounds elapsed seconds on ticks while playing.
// Output channel (out_valid / out_stall): exactly one status beat per event,
// carrying mode, selector, track, first visible list entry, elapsed seconds
// and the audio action code for that event.
// Config: APB-style port, registers at byte addresses 0x0 track count,
// 0x4 page size, 0x8 long press ticks. Write only while no event is in flight.
//
// Between input beat and output beat there is an input register,
// then one pass of next-state logic that writes the player state and the
// result register together. Throughput is one event per cycle; the state
// register feeds back into that single pass, so a new event is taken every
// cycle as long as the receiver keeps taking status beats.
// When the receiver stalls, the result register holds; the input register
// still takes one more beat, and in_stall rises once it is also full.
// Reset (synchronous, rst_n low) returns config to its defaults, the player
// to setup mode with the play button highlighted, and empties both stages.
module media_player_ui_control_unit
  import mpui_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // event input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_track_duration,
  // status output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_mode,
  output logic [1:0]  out_selector,
  output logic [7:0]  out_track_index,
  output logic [7:0]  out_first_visible,
  output logic [15:0] out_elapsed_seconds,
  output logic [2:0]  out_audio_action,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  ui_state_t   st_r;
  ui_state_t   st_nxt;
  logic [2:0]  act;

  // input stage
  logic        s1_vld_r;
  logic [2:0]  s1_cmd_r;
  logic [15:0] s1_dur_r;

  // result stage
  logic        out_vld_r;
  logic [2:0]  out_mode_r;
  logic [1:0]  out_sel_r;
  logic [7:0]  out_trk_r;
  logic [7:0]  out_top_r;
  logic [15:0] out_secs_r;
  logic [2:0]  out_act_r;

  logic        adv;     // result register free to load
  logic        fire;    // event in the input stage is processed this cycle

  mpui_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mpui_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .cmd    (s1_cmd_r),
    .dur    (s1_dur_r),
    .st_nxt (st_nxt),
    .act    (act)
  );

  assign adv      = ~out_vld_r | ~out_stall;
  assign fire     = s1_vld_r & adv;
  assign in_stall = s1_vld_r & ~adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_cmd_r <= in_cmd;
      s1_dur_r <= in_track_duration;
    end
  end

  // player state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode        <= MODE_SETUP;
      st_r.prior_mode  <= MODE_SETUP;
      st_r.selector    <= SEL_PLAY;
      st_r.track       <= 8'd0;
      st_r.top_entry   <= 8'd0;
      st_r.seconds     <= 16'd0;
      st_r.ticks       <= 32'd0;
      st_r.tick_mod    <= 7'd0;
      st_r.press_start <= 16'd0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_mode_r <= st_nxt.mode;
      out_sel_r  <= st_nxt.selector;
      out_trk_r  <= st_nxt.track;
      out_top_r  <= st_nxt.top_entry;
      out_secs_r <= st_nxt.seconds;
      out_act_r  <= act;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_mode            = out_mode_r;
  assign out_selector        = out_sel_r;
  assign out_track_index     = out_trk_r;
  assign out_first_visible   = out_top_r;
  assign out_elapsed_seconds = out_secs_r;
  assign out_audio_action    = out_act_r;

endmodule

// ===== sv/mpui_checker.sv =====
module mpui_checker
  import mpui_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_mode,
  input logic [15:0] out_elapsed_seconds,
  input logic [2:0]  out_audio_action
);

  // a stalled status beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mode))
    else $error("status beat dropped or changed under stall");

  // every audio action leaves the player in a transport mode
  a_act_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_audio_action != ACT_NONE |->
      out_mode == MODE_PLAY || out_mode == MODE_PAUSE)
    else $error("audio action outside play/pause");

  // track change restarts elapsed time
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_audio_action == ACT_NEXT || out_audio_action == ACT_PREV ||
                  out_audio_action == ACT_START) |-> out_elapsed_seconds == 16'd0)
    else $error("elapsed seconds not cleared on track change");

  // reset empties the output stage
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("status beat present after reset");

endmodule

bind media_player_ui_control_unit mpui_checker u_mpui_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_mode            (out_mode),
  .out_elapsed_seconds (out_elapsed_seconds),
  .out_audio_action    (out_audio_action)
);
